// ===== sv/gmdfs_pkg.sv =====
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared types, constants and helpers for the grid maze depth-first search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gmdfs_pkg;

	// Grid and storage geometry
	localparam int GRID_ROWS   = 4;
	localparam int GRID_COLS   = 4;
	localparam int STACK_DEPTH = 16;
	localparam int LOG_DEPTH   = 16;

	localparam int CELL_COUNT = GRID_ROWS * GRID_COLS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int STK_AW     = $clog2(STACK_DEPTH);
	localparam int STK_CW     = $clog2(STACK_DEPTH + 1);
	localparam int LOG_W      = $clog2(LOG_DEPTH + 1);

	// Field widths
	localparam int ROW_W    = 2;
	localparam int COL_W    = 2;
	localparam int KIND_W   = 2;
	localparam int STEP_W   = 5;
	localparam int STAT_W   = 3;
	localparam int DIM_W    = 3;
	localparam int CFG_IX_W = 1;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_RUN  = 1'b1
	} opcode_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_OPEN    = 2'd0,
		KIND_BLOCKED = 2'd1,
		KIND_START   = 2'd2,
		KIND_DEST    = 2'd3
	} kind_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_VISITING = 3'd0,
		STAT_REACHED  = 3'd1,
		STAT_NO_ROUTE = 3'd2,
		STAT_LOG_FULL = 3'd3,
		STAT_NO_START = 3'd4
	} status_t;

	typedef enum logic [CFG_IX_W-1:0] {
		CFG_ROWS = 1'b0,
		CFG_COLS = 1'b1
	} cfg_idx_t;

	// Neighbor scan order
	typedef enum logic [1:0] {
		NBR_ROW_INC = 2'd0,
		NBR_ROW_DEC = 2'd1,
		NBR_COL_INC = 2'd2,
		NBR_COL_DEC = 2'd3
	} nbr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_NO_START,
		ST_RD_CUR,
		ST_DEST,
		ST_NB_RD,
		ST_NB_CHK,
		ST_POP,
		ST_POP_WAIT
	} state_t;

	// Stack control and status
	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} stk_ctrl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} stk_stat_t;

	localparam logic [DIM_W-1:0] DIM_ROWS_MAX = DIM_W'(GRID_ROWS);
	localparam logic [DIM_W-1:0] DIM_COLS_MAX = DIM_W'(GRID_COLS);
	localparam logic [DIM_W-1:0] DIM_RESET    = 3'd3;

	function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v,
	                                               logic [DIM_W-1:0] hi);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

	function automatic logic [CELL_W-1:0] cell_idx(logic [ROW_W-1:0] row,
	                                               logic [COL_W-1:0] col);
		return CELL_W'(int'(row) * GRID_COLS + int'(col));
	endfunction

	function automatic logic [ROW_W-1:0] idx_row(logic [CELL_W-1:0] idx);
		return ROW_W'(int'(idx) / GRID_COLS);
	endfunction

	function automatic logic [COL_W-1:0] idx_col(logic [CELL_W-1:0] idx);
		return COL_W'(int'(idx) % GRID_COLS);
	endfunction

endpackage

`default_nettype wire

// ===== sv/gmdfs_if.sv =====
// ----------------------------------------------------------------------------
// gmdfs_if
// Valid/ready channels for commands in and visit results out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gmdfs_cmd_if
	import gmdfs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              opcode;
	logic [ROW_W-1:0]  cell_row;
	logic [COL_W-1:0]  cell_col;
	logic [KIND_W-1:0] cell_kind;

	modport source (output valid, opcode, cell_row, cell_col, cell_kind, input ready);
	modport sink   (input valid, opcode, cell_row, cell_col, cell_kind, output ready);
endinterface

interface gmdfs_res_if
	import gmdfs_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [ROW_W-1:0]  pos_row;
	logic [COL_W-1:0]  pos_col;
	logic [STEP_W-1:0] step_index;
	logic [STAT_W-1:0] status;
	logic              last;

	modport source (output valid, pos_row, pos_col, step_index, status, last, input ready);
	modport sink   (input valid, pos_row, pos_col, step_index, status, last, output ready);
endinterface

`default_nettype wire

// ===== sv/gmdfs_stack.sv =====
// ----------------------------------------------------------------------------
// gmdfs_stack
// Search stack: one-port-per-op RAM of cell indexes with a fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gmdfs_stack
	import gmdfs_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire stk_ctrl_t         ctrl,
	input  wire logic [CELL_W-1:0] push_cell,
	output logic      [CELL_W-1:0] pop_cell,
	output stk_stat_t              stat
);

	logic [CELL_W-1:0] mem [STACK_DEPTH];
	logic [STK_CW-1:0] count_q;
	logic [STK_CW-1:0] top_idx;

	assign top_idx    = count_q - STK_CW'(1);
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == STK_CW'(STACK_DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.push) begin
			count_q <= count_q + STK_CW'(1);
		end else if (ctrl.pop) begin
			count_q <= top_idx;
		end
	end

	// RAM: write on push, registered read of the top entry on pop
	always_ff @(posedge clk) begin
		if (ctrl.push)
			mem[count_q[STK_AW-1:0]] <= push_cell;
		if (ctrl.pop)
			pop_cell <= mem[top_idx[STK_AW-1:0]];
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |-> !stat.full)
		else $error("stack push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("stack pop while empty");

	a_push_pop_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctrl.push && ctrl.pop))
		else $error("stack push and pop in one cycle");

endmodule

`default_nettype wire

// ===== sv/grid_maze_depth_first_search_top.sv =====
// Load command: taken one per cycle back to back while idle; no result.
// Run command: a no-start result when no start lies in the region; otherwise, per
//   logged cell: cell read, log/emit, map read and check per neighbor in the region,
//   pop, pop read, one after another, as the cell map and stack RAM each have one read port.
// A new command is taken once the run's last result sits in the output register.
// Reset: control, visited flags, stack count and start are cleared at once; no clearing pass.
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search_top
// Depth-first walk over a small grid held in a cell-map RAM, with a stack RAM
// of pending cells and a visit log streamed out one result per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module grid_maze_depth_first_search_top
	import gmdfs_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [CFG_IX_W-1:0] cfg_index,
	input  wire logic [DIM_W-1:0]    cfg_data,
	gmdfs_cmd_if.sink                cmd,
	gmdfs_res_if.source              res
);

	// ------------------------------------------------------------------
	// Registers
	// ------------------------------------------------------------------
	state_t            state_q, state_d;
	logic [DIM_W-1:0]  rows_q, cols_q;
	logic [CELL_W-1:0] start_q;
	logic              start_vld_q;
	logic [CELL_W-1:0] cur_q;
	nbr_t              nb_q;
	logic [LOG_W-1:0]  log_cnt_q;
	logic [CELL_COUNT-1:0] visited_q;
	logic [CELL_W-1:0] nb_idx_q;

	// Output holding register
	logic              ov_q;
	logic [ROW_W-1:0]  o_row_q;
	logic [COL_W-1:0]  o_col_q;
	logic [STEP_W-1:0] o_step_q;
	status_t           o_stat_q;
	logic              o_last_q;

	// Cell map RAM
	logic [KIND_W-1:0] cell_mem [CELL_COUNT];
	logic [KIND_W-1:0] map_rd_q;
	logic              map_we, map_re;
	logic [CELL_W-1:0] map_wa, map_ra;

	// Stack
	stk_ctrl_t         stk_ctrl;
	stk_stat_t         stk_stat;
	logic [CELL_W-1:0] stk_pop_cell;

	// ------------------------------------------------------------------
	// Combinational helpers
	// ------------------------------------------------------------------
	logic [DIM_W-1:0]  er, ec;
	logic [ROW_W-1:0]  cur_row, st_row;
	logic [COL_W-1:0]  cur_col, st_col;
	logic              out_free;
	logic              cmd_xfer;
	logic              start_ok;
	logic              is_dest, log_full;
	logic              nb_in, nb_free;
	logic [CELL_W-1:0] nb_idx;

	// Strobes from the sequencer
	logic              emit;
	logic [CELL_W-1:0] e_cell;
	logic [STEP_W-1:0] e_step;
	status_t           e_stat;
	logic              e_last;
	logic              run_go, cur_ld_start, cur_ld_pop, vis_set, log_inc;
	logic              nb_clr, nb_inc;

	assign er       = clamp_dim(rows_q, DIM_ROWS_MAX);
	assign ec       = clamp_dim(cols_q, DIM_COLS_MAX);
	assign cur_row  = idx_row(cur_q);
	assign cur_col  = idx_col(cur_q);
	assign st_row   = idx_row(start_q);
	assign st_col   = idx_col(start_q);
	assign out_free = !ov_q || res.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_xfer = cmd.valid && cmd.ready;
	assign start_ok = start_vld_q && (DIM_W'(st_row) < er) && (DIM_W'(st_col) < ec);
	assign is_dest  = (kind_t'(map_rd_q) == KIND_DEST);
	assign log_full = (log_cnt_q >= LOG_W'(LOG_DEPTH));
	// Neighbor is pushable when it is not blocked and not yet visited
	assign nb_free  = (kind_t'(map_rd_q) != KIND_BLOCKED) && !visited_q[nb_idx_q];

	// Current neighbor: region check and index
	always_comb begin
		nb_in  = 1'b0;
		nb_idx = cur_q;
		unique case (nb_q)
			NBR_ROW_INC: begin
				nb_in  = (DIM_W'(cur_row) + DIM_W'(1)) < er;
				nb_idx = cur_q + CELL_W'(GRID_COLS);
			end
			NBR_ROW_DEC: begin
				nb_in  = (cur_row != '0);
				nb_idx = cur_q - CELL_W'(GRID_COLS);
			end
			NBR_COL_INC: begin
				nb_in  = (DIM_W'(cur_col) + DIM_W'(1)) < ec;
				nb_idx = cur_q + CELL_W'(1);
			end
			NBR_COL_DEC: begin
				nb_in  = (cur_col != '0);
				nb_idx = cur_q - CELL_W'(1);
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		emit         = 1'b0;
		e_cell       = cur_q;
		e_step       = STEP_W'(log_cnt_q);
		e_stat       = STAT_VISITING;
		e_last       = 1'b0;
		run_go       = 1'b0;
		cur_ld_start = 1'b0;
		cur_ld_pop   = 1'b0;
		vis_set      = 1'b0;
		log_inc      = 1'b0;
		nb_clr       = 1'b0;
		nb_inc       = 1'b0;
		map_we       = 1'b0;
		map_wa       = cell_idx(cmd.cell_row, cmd.cell_col);
		map_re       = 1'b0;
		map_ra       = cur_q;
		stk_ctrl     = '0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_xfer) begin
					if (opcode_t'(cmd.opcode) == OP_RUN) begin
						run_go        = 1'b1;
						stk_ctrl.clear = 1'b1;
						if (start_ok) begin
							cur_ld_start = 1'b1;
							state_d      = ST_RD_CUR;
						end else begin
							state_d = ST_NO_START;
						end
					end else begin
						map_we = (int'(cmd.cell_row) < GRID_ROWS) &&
						         (int'(cmd.cell_col) < GRID_COLS);
					end
				end
			end
			ST_NO_START: begin
				if (out_free) begin
					emit    = 1'b1;
					e_cell  = '0;
					e_step  = '0;
					e_stat  = STAT_NO_START;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_RD_CUR: begin
				map_re  = 1'b1;
				state_d = ST_DEST;
			end
			ST_DEST: begin
				if (out_free) begin
					emit = 1'b1;
					if (log_full) begin
						e_step  = STEP_W'(LOG_DEPTH);
						e_stat  = is_dest ? STAT_REACHED : STAT_LOG_FULL;
						e_last  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						e_stat  = is_dest ? STAT_REACHED : STAT_VISITING;
						e_last  = is_dest;
						log_inc = 1'b1;
						if (is_dest) begin
							state_d = ST_IDLE;
						end else begin
							vis_set = 1'b1;
							nb_clr  = 1'b1;
							state_d = ST_NB_RD;
						end
					end
				end
			end
			ST_NB_RD: begin
				if (nb_in) begin
					map_re  = 1'b1;
					map_ra  = nb_idx;
					state_d = ST_NB_CHK;
				end else if (nb_q == NBR_COL_DEC) begin
					state_d = ST_POP;
				end else begin
					nb_inc = 1'b1;
				end
			end
			ST_NB_CHK: begin
				// pushes to a full stack are dropped
				stk_ctrl.push = nb_free && !stk_stat.full;
				if (nb_q == NBR_COL_DEC) begin
					state_d = ST_POP;
				end else begin
					nb_inc  = 1'b1;
					state_d = ST_NB_RD;
				end
			end
			ST_POP: begin
				if (!stk_stat.empty) begin
					stk_ctrl.pop = 1'b1;
					state_d      = ST_POP_WAIT;
				end else if (out_free) begin
					emit    = 1'b1;
					e_stat  = STAT_NO_ROUTE;
					e_last  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_POP_WAIT: begin
				cur_ld_pop = 1'b1;
				state_d    = ST_RD_CUR;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control and search state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q      <= DIM_RESET;
			cols_q      <= DIM_RESET;
			start_q     <= '0;
			start_vld_q <= 1'b0;
			cur_q       <= '0;
			nb_q        <= NBR_ROW_INC;
			log_cnt_q   <= '0;
			visited_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_ROWS: rows_q <= cfg_data;
					CFG_COLS: cols_q <= cfg_data;
				endcase
			end
			// last start loaded wins; overwriting the start cell drops it
			if (map_we) begin
				if (kind_t'(cmd.cell_kind) == KIND_START) begin
					start_q     <= map_wa;
					start_vld_q <= 1'b1;
				end else if (map_wa == start_q) begin
					start_vld_q <= 1'b0;
				end
			end
			if (run_go) begin
				visited_q <= '0;
				log_cnt_q <= '0;
			end else begin
				if (vis_set)
					visited_q[cur_q] <= 1'b1;
				if (log_inc)
					log_cnt_q <= log_cnt_q + LOG_W'(1);
			end
			if (cur_ld_start)
				cur_q <= start_q;
			else if (cur_ld_pop)
				cur_q <= stk_pop_cell;
			if (nb_clr)
				nb_q <= NBR_ROW_INC;
			else if (nb_inc)
				nb_q <= nbr_t'(nb_q + 2'd1);
		end
	end

	// Neighbor index held for the push after its map read
	always_ff @(posedge clk) begin
		if (map_re)
			nb_idx_q <= map_ra;
	end

	// Cell map RAM: one write, one registered read
	always_ff @(posedge clk) begin
		if (map_we)
			cell_mem[map_wa] <= cmd.cell_kind;
		if (map_re)
			map_rd_q <= cell_mem[map_ra];
	end

	gmdfs_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (stk_ctrl),
		.push_cell (nb_idx_q),
		.pop_cell  (stk_pop_cell),
		.stat      (stk_stat)
	);

	// ------------------------------------------------------------------
	// Output register: holds a result until its transfer
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (emit)
			ov_q <= 1'b1;
		else if (res.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			o_row_q  <= idx_row(e_cell);
			o_col_q  <= idx_col(e_cell);
			o_step_q <= e_step;
			o_stat_q <= e_stat;
			o_last_q <= e_last;
		end
	end

	assign res.valid      = ov_q;
	assign res.pos_row    = o_row_q;
	assign res.pos_col    = o_col_q;
	assign res.step_index = o_step_q;
	assign res.status     = o_stat_q;
	assign res.last       = o_last_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_log_bound: assert property (@(posedge clk) disable iff (!arst_n)
		log_cnt_q <= LOG_W'(LOG_DEPTH))
		else $error("log count beyond log depth");

	a_cur_visited: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NB_CHK) |-> visited_q[cur_q])
		else $error("neighbor check before current cell marked visited");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready) |=> (res.valid && $stable({res.pos_row, res.pos_col,
			res.step_index, res.status, res.last})))
		else $error("result changed while waiting for its transfer");

endmodule

`default_nettype wire

// ===== dv/grid_maze_depth_first_search_top_tb.sv =====
// ----------------------------------------------------------------------------
// grid_maze_depth_first_search_top_tb
// Self-checking bench for the grid depth-first search block. It loads cells,
// runs searches over many region sizes and predicts every visit result. Each
// result is checked as it arrives, with random stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_maze_depth_first_search_top_tb;
	import gmdfs_pkg::*;

	localparam int RANDOM_ITEMS  = 160;
	localparam int CALM_ITEMS    = 40;   // final stretch with no idling
	localparam int HOLD_CYCLES   = 300;  // long result back-pressure
	localparam int SETTLE_CYCLES = 30;   // idle margin before a register write
	localparam int QUIET_LIMIT   = 3000; // cycles without any transfer
	localparam int REPORT_MAX    = 10;

	typedef struct packed {
		opcode_t          op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		kind_t            kind;
	} cmd_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [STEP_W-1:0] step_ix;
		status_t           status;
		logic              last;
	} visit_t;

	// One line of the directed plan: either a region change or one command.
	// typed marks a run whose single result is written out below by hand.
	typedef struct packed {
		logic             set_dims;
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		cmd_t             cmd;
		logic             typed;
		visit_t           want;
	} plan_row_t;

	localparam cmd_t   RUN_CMD       = '{OP_RUN, 2'd0, 2'd0, KIND_OPEN};
	localparam visit_t NO_VISIT      = '0;
	localparam visit_t NO_START_SEEN = '{2'd0, 2'd0, 5'd0, STAT_NO_START, 1'b1};
	localparam int     PLAN_LEN      = 29;

	// The whole grid is written open before this plan starts, so no search
	// ever reads a cell that was never loaded.
	plan_row_t plan [PLAN_LEN] = '{
		// run straight after reset: no start cell known yet
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b1, NO_START_SEEN},
		// single-cell region: start logged, then no route
		'{1'b1, 3'd1, 3'd1, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd0, 2'd0, KIND_START}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		// another kind loaded onto the start cell drops the start
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd0, 2'd0, KIND_DEST}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b1, NO_START_SEEN},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd0, 2'd0, KIND_START}, 1'b0, NO_VISIT},
		// zero-sized region counts as one row, one column
		'{1'b1, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		// oversized region clamps to the full grid
		'{1'b1, 3'd7, 3'd7, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd3, 2'd3, KIND_DEST}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		// a later start wins; far corner walled in by blocked cells
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd3, 2'd3, KIND_START}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd0, 2'd0, KIND_DEST}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd2, 2'd3, KIND_BLOCKED}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd3, 2'd2, KIND_BLOCKED}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		// start left outside a shrunk region
		'{1'b1, 3'd2, 3'd4, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b1, NO_START_SEEN},
		// open grid with no destination: the visit log fills up
		'{1'b1, 3'd4, 3'd4, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd2, 2'd3, KIND_OPEN}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd3, 2'd2, KIND_OPEN}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd0, 2'd0, KIND_OPEN}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd1, 2'd2, KIND_DEST}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT},
		// one-column region, destination out of reach
		'{1'b1, 3'd4, 3'd1, RUN_CMD, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, '{OP_LOAD, 2'd3, 2'd0, KIND_START}, 1'b0, NO_VISIT},
		'{1'b0, 3'd0, 3'd0, RUN_CMD, 1'b0, NO_VISIT}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [CFG_IX_W-1:0] cfg_index;
	logic [DIM_W-1:0]    cfg_data;

	gmdfs_cmd_if cmd();
	gmdfs_res_if res();

	grid_maze_depth_first_search_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.res       (res)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shadow of the block: grid contents, start cell, region registers.
	kind_t            grid_kind [CELL_COUNT];
	logic [CELL_W-1:0] start_at;
	logic             start_ok;
	logic [DIM_W-1:0] rows_reg;
	logic [DIM_W-1:0] cols_reg;
	visit_t           visit_q [$];   // visit results still due, oldest first

	int   loads_sent   = 0;
	int   runs_sent    = 0;
	int   dim_writes   = 0;
	int   results_seen = 0;
	int   faults       = 0;
	int   closes [5]   = '{default: 0};
	int   quiet_cycles = 0;
	logic hold_req;
	logic calm;
	logic tx_lively;

	function automatic int eff_dim(logic [DIM_W-1:0] v, int hi);
		if (v == '0)
			return 1;
		if (int'(v) > hi)
			return hi;
		return int'(v);
	endfunction

	function automatic void log_visit(int cell_ix, int step_ix, status_t st, logic fin);
		visit_t v;
		v.row     = ROW_W'(cell_ix / GRID_COLS);
		v.col     = COL_W'(cell_ix % GRID_COLS);
		v.step_ix = STEP_W'(step_ix);
		v.status  = st;
		v.last    = fin;
		visit_q.push_back(v);
	endfunction

	function automatic void apply_load(cmd_t c);
		int idx;
		idx = int'(c.row) * GRID_COLS + int'(c.col);
		grid_kind[idx] = c.kind;
		if (c.kind == KIND_START) begin
			start_at = CELL_W'(idx);
			start_ok = 1'b1;
		end else if (start_ok && idx == int'(start_at)) begin
			start_ok = 1'b0;
		end
	endfunction

	// Depth-first walk: log the cell, mark it, push open neighbors in scan
	// order (full stack drops the push), pop the newest and go again.
	function automatic void walk_grid();
		int   rlim, clim, cur, logged, r, c, nr, nc, nxt, d;
		logic reach, done;
		logic seen [CELL_COUNT];
		int   pend [$];
		rlim = eff_dim(rows_reg, GRID_ROWS);
		clim = eff_dim(cols_reg, GRID_COLS);
		seen = '{default: 1'b0};
		if (!start_ok || int'(start_at) / GRID_COLS >= rlim ||
		    int'(start_at) % GRID_COLS >= clim) begin
			log_visit(0, 0, STAT_NO_START, 1'b1);
			return;
		end
		cur    = int'(start_at);
		logged = 0;
		done   = 1'b0;
		while (!done) begin
			reach = (grid_kind[cur] == KIND_DEST);
			if (logged >= LOG_DEPTH) begin
				log_visit(cur, LOG_DEPTH, reach ? STAT_REACHED : STAT_LOG_FULL, 1'b1);
				done = 1'b1;
			end else begin
				log_visit(cur, logged, reach ? STAT_REACHED : STAT_VISITING, reach);
				logged++;
				if (reach) begin
					done = 1'b1;
				end else begin
					seen[cur] = 1'b1;
					r = cur / GRID_COLS;
					c = cur % GRID_COLS;
					for (d = 0; d < 4; d++) begin
						nr = r;
						nc = c;
						case (nbr_t'(d))
							NBR_ROW_INC: nr = r + 1;
							NBR_ROW_DEC: nr = r - 1;
							NBR_COL_INC: nc = c + 1;
							default:     nc = c - 1;
						endcase
						if (nr >= 0 && nr < rlim && nc >= 0 && nc < clim) begin
							nxt = nr * GRID_COLS + nc;
							if (grid_kind[nxt] != KIND_BLOCKED && !seen[nxt] &&
							    pend.size() < STACK_DEPTH)
								pend.push_back(nxt);
						end
					end
					if (pend.size() == 0) begin
						log_visit(cur, logged, STAT_NO_ROUTE, 1'b1);
						done = 1'b1;
					end else begin
						cur = pend.pop_back();
					end
				end
			end
		end
	endfunction

	// Offer one command, optionally after an idle burst, and hold it until
	// the transfer. The shadow is updated at the accepting edge.
	task automatic send_cmd(input cmd_t c, input logic typed = 1'b0,
	                        input visit_t want = '0);
		int gap;
		if (!calm && tx_lively && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd.valid     <= 1'b1;
		cmd.opcode    <= c.op;
		cmd.cell_row  <= c.row;
		cmd.cell_col  <= c.col;
		cmd.cell_kind <= c.kind;
		@(posedge clk);
		while (!cmd.ready) @(posedge clk);
		if (c.op == OP_LOAD) begin
			loads_sent++;
			apply_load(c);
		end else begin
			runs_sent++;
			if (typed)
				visit_q.push_back(want);
			else
				walk_grid();
		end
	endtask

	// Loads give no result, so after the last run result the block gets a
	// margin of idle cycles before anything touches the registers.
	task automatic settle();
		cmd.valid <= 1'b0;
		while (visit_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_dims(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] c);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_ROWS;
		cfg_data  <= r;
		@(posedge clk);
		cfg_index <= CFG_COLS;
		cfg_data  <= c;
		@(posedge clk);
		cfg_we   <= 1'b0;
		rows_reg = r;
		cols_reg = c;
		dim_writes++;
	endtask

	// Result side: random stall bursts, one long hold-off on request, and
	// none at all once the final stretch starts.
	initial begin
		int   stall_left;
		logic hold_done;
		stall_left = 0;
		hold_done  = 1'b0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_done  = 1'b1;
				stall_left = HOLD_CYCLES;
			end else if (stall_left == 0 && !calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 16);
			end
			if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= arst_n;
			end
		end
	end

	// Result checker: every transfer is matched against the oldest prediction.
	always @(posedge clk) begin
		visit_t got, want;
		if (arst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1) begin
			got = '{res.pos_row, res.pos_col, res.step_index, status_t'(res.status), res.last};
			results_seen++;
			if (visit_q.size() == 0) begin
				faults++;
				if (faults <= REPORT_MAX)
					$display("Unexpected result: row %0d col %0d step %0d status %0d last %0d",
					         got.row, got.col, got.step_ix, got.status, got.last);
			end else begin
				want = visit_q.pop_front();
				if (want.last)
					closes[int'(want.status)]++;
				if (got.row !== want.row || got.col !== want.col ||
				    got.step_ix !== want.step_ix || got.status !== want.status ||
				    got.last !== want.last) begin
					faults++;
					if (faults <= REPORT_MAX)
						$display({"Mismatch on result %0d: expected row %0d col %0d step %0d ",
						          "status %0d last %0d, got row %0d col %0d step %0d ",
						          "status %0d last %0d"}, results_seen,
						         want.row, want.col, want.step_ix, want.status, want.last,
						         got.row, got.col, got.step_ix, got.status, got.last);
				end
			end
		end
	end

	// Watchdog: counts cycles with no transfer on either channel.
	always @(posedge clk) begin
		if ((cmd.valid === 1'b1 && cmd.ready === 1'b1) ||
		    (res.valid === 1'b1 && res.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("Timeout: no transfer for %0d cycles, %0d results still due",
		         QUIET_LIMIT, visit_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	// Main sequence: reset, grid fill, directed plan, random mazes, drain.
	initial begin
		cmd_t             item;
		int               base, seq, n, pick;
		logic [DIM_W-1:0] dr, dc;

		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_ROWS;
		cfg_data      <= '0;
		cmd.valid     <= 1'b0;
		cmd.opcode    <= OP_LOAD;
		cmd.cell_row  <= '0;
		cmd.cell_col  <= '0;
		cmd.cell_kind <= KIND_OPEN;
		hold_req  = 1'b0;
		calm      = 1'b0;
		tx_lively = 1'b1;
		start_ok  = 1'b0;
		start_at  = '0;
		rows_reg  = DIM_RESET;
		cols_reg  = DIM_RESET;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Cell map is undefined until written: open every cell first.
		for (int i = 0; i < CELL_COUNT; i++) begin
			item = '{OP_LOAD, ROW_W'(i / GRID_COLS), COL_W'(i % GRID_COLS), KIND_OPEN};
			send_cmd(item);
		end

		foreach (plan[i]) begin
			if (plan[i].set_dims) begin
				settle();
				write_dims(plan[i].rows, plan[i].cols);
			end else begin
				send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);
			end
		end

		// Random mazes: a handful of cell loads, usually a start inside the
		// region, then a run. Region changes every few mazes.
		base = loads_sent + runs_sent;
		seq  = 0;
		while (loads_sent + runs_sent - base < RANDOM_ITEMS) begin
			if (seq % 6 == 0) begin
				settle();
				if ($urandom_range(0, 3) == 0)
					dr = DIM_W'($urandom_range(0, 7));
				else
					dr = DIM_W'($urandom_range(1, 4));
				if ($urandom_range(0, 3) == 0)
					dc = DIM_W'($urandom_range(0, 7));
				else
					dc = DIM_W'($urandom_range(1, 4));
				write_dims(dr, dc);
			end
			// hold the result side while commands keep coming, so the
			// block fills up and stops taking commands
			if (seq == 3)
				hold_req = 1'b1;
			calm      = (loads_sent + runs_sent - base >= RANDOM_ITEMS - CALM_ITEMS);
			tx_lively = ($urandom_range(0, 2) != 0);

			n = $urandom_range(0, 8);
			repeat (n) begin
				item.op  = OP_LOAD;
				item.row = ROW_W'($urandom_range(0, 3));
				item.col = COL_W'($urandom_range(0, 3));
				pick     = $urandom_range(0, 19);
				if (pick < 9)
					item.kind = KIND_OPEN;
				else if (pick < 15)
					item.kind = KIND_BLOCKED;
				else if (pick < 18)
					item.kind = KIND_DEST;
				else
					item.kind = KIND_START;
				send_cmd(item);
			end

			// mostly a start inside the region; sometimes anywhere, sometimes none
			pick = $urandom_range(0, 9);
			if (pick < 9) begin
				item.op   = OP_LOAD;
				item.kind = KIND_START;
				if (pick < 8) begin
					item.row = ROW_W'($urandom_range(0, eff_dim(rows_reg, GRID_ROWS) - 1));
					item.col = COL_W'($urandom_range(0, eff_dim(cols_reg, GRID_COLS) - 1));
				end else begin
					item.row = ROW_W'($urandom_range(0, 3));
					item.col = COL_W'($urandom_range(0, 3));
				end
				send_cmd(item);
			end

			send_cmd(RUN_CMD);
			seq++;
		end

		calm = 1'b1;
		settle();

		$display("Covered %0d cell loads and %0d searches over %0d region settings;",
		         loads_sent, runs_sent, dim_writes);
		$display("%0d results checked.", results_seen);
		$display("Search endings: reached %0d, no route %0d, log full %0d, no start %0d.",
		         closes[int'(STAT_REACHED)], closes[int'(STAT_NO_ROUTE)],
		         closes[int'(STAT_LOG_FULL)], closes[int'(STAT_NO_START)]);
		if (faults == 0 && visit_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d failures, %0d results still due", faults, visit_q.size());
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
